/* rtl/binomial_coefficient_table_assert.svh */
// Assertion macros shared by the binomial table RTL.
// Expects clk and rst_n in the scope of every module that uses them.
`ifndef BINOMIAL_COEFFICIENT_TABLE_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BCT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define BCT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bct_pkg.sv */
// Shared types and constants for the binomial coefficient table.
// No dependencies; used by every RTL module of the block.
package bct_pkg;

    // Default triangle capacity in rows
    localparam int unsigned MAX_ROWS_DEF = 64;
    // Rows a build can ever produce (max_row is 6 bits)
    localparam int unsigned ROWS_LIMIT   = 64;

    localparam int unsigned COEF_W       = 64;
    localparam int unsigned IDX_W        = 8;
    localparam int unsigned MAX_ROW_W    = 6;
    localparam int unsigned ROWS_W       = 7;

    localparam logic [MAX_ROW_W-1:0] MAX_ROW_RESET = 6'd63;

    // Item opcodes
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // APB register map
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic REG_MAX_ROW = 1'b0;

    // One triangle entry: sticky overflow mark plus value
    typedef struct packed {
        logic              ovf;
        logic [COEF_W-1:0] value;
    } entry_t;

endpackage

/* rtl/binomial_coefficient_table.sv */
// Binomial coefficient table: a Pascal-triangle store filled by build items and
// read by query items. A query passes the range check and slot address, one
// registered store read, the result register and the output register; an
// out-of-range query skips the read. A build walks the triangle in slot order
// with one shared 64-bit adder and the store's one write port: an edge entry is
// written directly, an interior entry takes a parent read, then sum and write;
// the finished build then passes the output stage. The block takes one item at a
// time; the input stalls until the sequencer is back at idle, though a finished
// result may still wait in the output register. Entries are valid only after a
// build; no clearing pass runs after reset.
module binomial_coefficient_table
#(
    parameter int unsigned MAX_ROWS = bct_pkg::MAX_ROWS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [bct_pkg::IDX_W-1:0]           row_index,
    input  logic [bct_pkg::IDX_W-1:0]           column_index,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bct_pkg::COEF_W-1:0]   coefficient,
    output logic                                overflowed,
    output logic                                out_of_range,
    output logic [bct_pkg::ROWS_W-1:0]          rows_built,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bct_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bct_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bct_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int unsigned DEPTH  = MAX_ROWS * (MAX_ROWS + 1) / 2;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic [bct_pkg::MAX_ROW_W-1:0] max_row;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             rd_addr;
    bct_pkg::entry_t               wr_data;
    bct_pkg::entry_t               rd_data;
    bct_pkg::entry_t               sum_a;
    bct_pkg::entry_t               sum_b;
    bct_pkg::entry_t               sum_res;
    logic [bct_pkg::COEF_W-1:0]    coef_raw;

    // Configuration register
    bct_apb u_apb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_row (max_row)
    );

    // Triangle memory
    bct_store
    #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    )
    u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared Pascal adder
    bct_sum u_sum
    (
        .left_parent  (sum_a),
        .right_parent (sum_b),
        .sum          (sum_res)
    );

    // Sequencer
    bct_ctrl
    #(
        .MAX_ROWS (MAX_ROWS),
        .ADDR_W   (ADDR_W)
    )
    u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .row_index    (row_index),
        .column_index (column_index),
        .max_row      (max_row),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .sum_a        (sum_a),
        .sum_b        (sum_b),
        .sum_res      (sum_res),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coefficient  (coef_raw),
        .overflowed   (overflowed),
        .out_of_range (out_of_range),
        .rows_built   (rows_built)
    );

    assign coefficient = $signed(coef_raw);

endmodule

/* rtl/bct_apb.sv */
// APB configuration register (max_row) for the binomial table.
// Depends on bct_pkg.
module bct_apb
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bct_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bct_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bct_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [bct_pkg::MAX_ROW_W-1:0]       max_row
);

    logic [bct_pkg::MAX_ROW_W-1:0] max_row_reg;
    logic [bct_pkg::MAX_ROW_W-1:0] max_row_next;
    logic                          sel_max_row;

    assign pready      = 1'b1;
    assign sel_max_row = (paddr[bct_pkg::APB_ADDR_W-1] == bct_pkg::REG_MAX_ROW);

    // Register write on the access phase
    always_comb
    begin
        max_row_next = max_row_reg;
        if (psel && penable && pwrite && sel_max_row)
        begin
            max_row_next = pwdata[bct_pkg::MAX_ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_row_reg <= bct_pkg::MAX_ROW_RESET;
        end
        else
        begin
            max_row_reg <= max_row_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (sel_max_row)
        begin
            prdata = {{(bct_pkg::APB_DATA_W - bct_pkg::MAX_ROW_W){1'b0}}, max_row_reg};
        end
    end

    assign max_row = max_row_reg;

endmodule

/* rtl/bct_store.sv */
// Triangle store: one write port, one registered read port.
// Depends on bct_pkg for the entry type.
module bct_store
#(
    parameter int unsigned DEPTH  = 2080,
    parameter int unsigned ADDR_W = 12
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  bct_pkg::entry_t       wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output bct_pkg::entry_t       rd_data
);

    bct_pkg::entry_t mem [DEPTH];
    bct_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bct_sum.sv */
// Pascal adder: sums two parent entries with sticky overflow.
// Depends on bct_pkg for the entry type.
module bct_sum
(
    input  bct_pkg::entry_t left_parent,
    input  bct_pkg::entry_t right_parent,
    output bct_pkg::entry_t sum
);

    logic [bct_pkg::COEF_W-1:0] raw;

    // Unmarked parents are below 2^63, so the sum never wraps; bit 63 flags overflow
    assign raw       = left_parent.value + right_parent.value;
    assign sum.value = raw;
    assign sum.ovf   = left_parent.ovf | right_parent.ovf | raw[bct_pkg::COEF_W-1];

endmodule

/* rtl/bct_ctrl.sv */
// Sequencer for the binomial table: build walk, query lookup, output register.
// Depends on bct_pkg and the assertion macro header.
`include "binomial_coefficient_table_assert.svh"

module bct_ctrl
#(
    parameter int unsigned MAX_ROWS = bct_pkg::MAX_ROWS_DEF,
    parameter int unsigned ADDR_W   = 12
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic [bct_pkg::IDX_W-1:0]          row_index,
    input  logic [bct_pkg::IDX_W-1:0]          column_index,
    // configuration
    input  logic [bct_pkg::MAX_ROW_W-1:0]      max_row,
    // store
    output logic                               wr_en,
    output logic [ADDR_W-1:0]                  wr_addr,
    output bct_pkg::entry_t                    wr_data,
    output logic [ADDR_W-1:0]                  rd_addr,
    input  bct_pkg::entry_t                    rd_data,
    // adder
    output bct_pkg::entry_t                    sum_a,
    output bct_pkg::entry_t                    sum_b,
    input  bct_pkg::entry_t                    sum_res,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [bct_pkg::COEF_W-1:0]         coefficient,
    output logic                               overflowed,
    output logic                               out_of_range,
    output logic [bct_pkg::ROWS_W-1:0]         rows_built
);

    localparam int unsigned DEPTH    = MAX_ROWS * (MAX_ROWS + 1) / 2;
    localparam int unsigned ROWS_CAP = (MAX_ROWS > bct_pkg::ROWS_LIMIT) ?
                                       bct_pkg::ROWS_LIMIT : MAX_ROWS;
    localparam int unsigned ROW_W    = $clog2(ROWS_CAP);
    localparam int unsigned PROD_RAW = 2 * ROW_W + 2;
    localparam int unsigned PROD_W   = (PROD_RAW > ADDR_W) ? PROD_RAW : ADDR_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_B_ISSUE = 6'b000010,
        S_B_WRITE = 6'b000100,
        S_Q_ADDR  = 6'b001000,
        S_Q_READ  = 6'b010000,
        S_OUT     = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ROW_W-1:0]                row_reg, row_next;
    logic [ROW_W-1:0]                col_reg, col_next;
    logic [ADDR_W-1:0]               wa_reg, wa_next;
    bct_pkg::entry_t                 prev_reg, prev_next;
    logic [bct_pkg::ROWS_W-1:0]      tgt_reg, tgt_next;
    logic [bct_pkg::ROWS_W-1:0]      built_reg, built_next;
    logic [bct_pkg::IDX_W-1:0]       qn_reg, qn_next;
    logic [bct_pkg::IDX_W-1:0]       qk_reg, qk_next;
    logic [bct_pkg::COEF_W-1:0]      res_coef_reg, res_coef_next;
    logic                            res_ovf_reg, res_ovf_next;
    logic                            res_rng_reg, res_rng_next;
    logic                            out_valid_reg, out_valid_next;
    logic [bct_pkg::COEF_W-1:0]      coef_out_reg, coef_out_next;
    logic                            ovf_out_reg, ovf_out_next;
    logic                            rng_out_reg, rng_out_next;
    logic [bct_pkg::ROWS_W-1:0]      rows_out_reg, rows_out_next;

    logic                            accept;
    logic                            out_free;
    logic                            edge_entry;
    logic                            entry_done;
    logic                            row_last;
    logic                            build_last;
    logic [bct_pkg::ROWS_W-1:0]      rows_req;
    logic [ADDR_W-1:0]               parent_addr;
    logic                            q_range;
    logic [ROW_W:0]                  qn_ext, qn_inc;
    logic [PROD_W-1:0]               q_prod;
    logic [PROD_W-1:0]               q_slot;
    bct_pkg::entry_t                 one_entry;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign one_entry.ovf   = 1'b0;
    assign one_entry.value = {{(bct_pkg::COEF_W-1){1'b0}}, 1'b1};

    // Row count a build produces, capped at the store's rows
    assign rows_req = (bct_pkg::ROWS_W'(max_row) + 1'b1 > bct_pkg::ROWS_W'(ROWS_CAP)) ?
                      bct_pkg::ROWS_W'(ROWS_CAP) : bct_pkg::ROWS_W'(max_row) + 1'b1;

    // Build walk: entries are written in slot order, parent (n-1,k) sits n slots back
    assign edge_entry  = (col_reg == '0) || (col_reg == row_reg);
    assign row_last    = (col_reg == row_reg);
    assign build_last  = (bct_pkg::ROWS_W'(row_reg) + 1'b1 == tgt_reg);
    assign parent_addr = wa_reg - {{(ADDR_W-ROW_W){1'b0}}, row_reg};
    assign entry_done  = ((state_reg == S_B_ISSUE) && edge_entry) || (state_reg == S_B_WRITE);

    // Query slot n*(n+1)/2 + k; only used when n and k are in range
    assign q_range = (qn_reg >= bct_pkg::IDX_W'(built_reg)) || (qk_reg > qn_reg);
    assign qn_ext  = {1'b0, qn_reg[ROW_W-1:0]};
    assign qn_inc  = qn_ext + 1'b1;
    assign q_prod  = PROD_W'(qn_ext) * PROD_W'(qn_inc);
    assign q_slot  = (q_prod >> 1) + {{(PROD_W-ROW_W){1'b0}}, qk_reg[ROW_W-1:0]};

    // Adder operands: left parent held, right parent from the store
    assign sum_a = prev_reg;
    assign sum_b = rd_data;

    // Store ports
    assign wr_en   = entry_done;
    assign wr_addr = wa_reg;
    assign wr_data = (state_reg == S_B_WRITE) ? sum_res : one_entry;
    assign rd_addr = (state_reg == S_Q_ADDR) ? q_slot[ADDR_W-1:0] : parent_addr;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        wa_next       = wa_reg;
        prev_next     = prev_reg;
        tgt_next      = tgt_reg;
        built_next    = built_reg;
        qn_next       = qn_reg;
        qk_next       = qk_reg;
        res_coef_next = res_coef_reg;
        res_ovf_next  = res_ovf_reg;
        res_rng_next  = res_rng_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    qn_next = row_index;
                    qk_next = column_index;
                    if (opcode == bct_pkg::OP_BUILD)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        wa_next    = '0;
                        tgt_next   = rows_req;
                        state_next = S_B_ISSUE;
                    end
                    else
                    begin
                        state_next = S_Q_ADDR;
                    end
                end
            end
            S_B_ISSUE:
            begin
                if (edge_entry)
                begin
                    prev_next = one_entry;
                end
                else
                begin
                    state_next = S_B_WRITE;
                end
            end
            S_B_WRITE:
            begin
                prev_next  = rd_data;
                state_next = S_B_ISSUE;
            end
            S_Q_ADDR:
            begin
                if (q_range)
                begin
                    res_coef_next = '0;
                    res_ovf_next  = 1'b0;
                    res_rng_next  = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    state_next = S_Q_READ;
                end
            end
            S_Q_READ:
            begin
                res_coef_next = rd_data.ovf ? '1 : rd_data.value;
                res_ovf_next  = rd_data.ovf;
                res_rng_next  = 1'b0;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Advance the build walk after each written entry
        if (entry_done)
        begin
            wa_next = wa_reg + 1'b1;
            if (row_last)
            begin
                if (build_last)
                begin
                    built_next    = tgt_reg;
                    res_coef_next = '0;
                    res_ovf_next  = 1'b0;
                    res_rng_next  = 1'b0;
                    state_next    = S_OUT;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    col_next   = '0;
                    state_next = S_B_ISSUE;
                end
            end
            else
            begin
                col_next   = col_reg + 1'b1;
                state_next = S_B_ISSUE;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        coef_out_next  = coef_out_reg;
        ovf_out_next   = ovf_out_reg;
        rng_out_next   = rng_out_reg;
        rows_out_next  = rows_out_reg;
        if ((state_reg == S_OUT) && out_free)
        begin
            out_valid_next = 1'b1;
            coef_out_next  = res_coef_reg;
            ovf_out_next   = res_ovf_reg;
            rng_out_next   = res_rng_reg;
            rows_out_next  = built_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            built_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        wa_reg       <= wa_next;
        prev_reg     <= prev_next;
        tgt_reg      <= tgt_next;
        qn_reg       <= qn_next;
        qk_reg       <= qk_next;
        res_coef_reg <= res_coef_next;
        res_ovf_reg  <= res_ovf_next;
        res_rng_reg  <= res_rng_next;
        coef_out_reg <= coef_out_next;
        ovf_out_reg  <= ovf_out_next;
        rng_out_reg  <= rng_out_next;
        rows_out_reg <= rows_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign coefficient  = coef_out_reg;
    assign overflowed   = ovf_out_reg;
    assign out_of_range = rng_out_reg;
    assign rows_built   = rows_out_reg;

    // Checks
    `BCT_ASSERT_NXT(a_query_starts, accept && (opcode == bct_pkg::OP_QUERY), state_reg == S_Q_ADDR, "query item did not start lookup")
    `BCT_ASSERT_IMP(a_build_addr, wr_en, wa_reg < ADDR_W'(DEPTH), "build write past end of store")
    `BCT_ASSERT_IMP(a_result_from_out, $rose(out_valid_reg), $past(state_reg == S_OUT), "result appeared outside output state")
    `BCT_ASSERT_IMP(a_count_from_build, built_reg != $past(built_reg), $past(state_reg == S_B_ISSUE || state_reg == S_B_WRITE), "row count changed outside a build")

endmodule

/* verif/coefficient_checker.sv */
// Checker for the binomial coefficient table: watches the item channels and the
// register port, keeps its own Pascal triangle and compares every result.
// Depends on bct_pkg for widths, opcodes and the register index.
module coefficient_checker
#(
    parameter int unsigned ROWS = bct_pkg::MAX_ROWS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                opcode,
    input  logic [bct_pkg::IDX_W-1:0]           row_index,
    input  logic [bct_pkg::IDX_W-1:0]           column_index,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [bct_pkg::COEF_W-1:0]   coefficient,
    input  logic                                overflowed,
    input  logic                                out_of_range,
    input  logic [bct_pkg::ROWS_W-1:0]          rows_built,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bct_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bct_pkg::APB_DATA_W-1:0]      pwdata,
    input  logic [bct_pkg::APB_DATA_W-1:0]      prdata,
    input  logic                                pready,
    output int unsigned                         mismatches,
    output int unsigned                         pending,
    output int unsigned                         results_checked,
    output int unsigned                         builds_seen,
    output int unsigned                         range_errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import bct_pkg::*;

    localparam int unsigned DEPTH = ROWS * (ROWS + 1) / 2;
    localparam logic [APB_ADDR_W-1:0] MAX_ROW_ADDR = APB_ADDR_W'(4 * REG_MAX_ROW);
    localparam logic [COEF_W-1:0] SIGNED_MAX = {1'b0, {(COEF_W-1){1'b1}}};

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic                     ovf;
        logic                     oor;
        logic [ROWS_W-1:0]        rows;
    } coef_reply_t;

    // Shadow triangle, row count and register
    logic [COEF_W-1:0]    tri_value [DEPTH];
    logic                 tri_ovf   [DEPTH];
    logic [ROWS_W-1:0]    rows_in_table = '0;
    logic [MAX_ROW_W-1:0] max_row_cfg = MAX_ROW_RESET;

    coef_reply_t expected_coefs [$];
    coef_reply_t want;
    int unsigned err_count = 0;
    int unsigned n_checked = 0;
    int unsigned n_builds = 0;
    int unsigned n_range = 0;

    function automatic int unsigned slot_of(int unsigned n, int unsigned k);
        return n * (n + 1) / 2 + k;
    endfunction

    // Pascal's rule over rows 0..max_row capped at ROWS, overflow mark sticky from either parent
    function automatic void fill_triangle();
        int unsigned      rows;
        int unsigned      pa;
        int unsigned      pb;
        logic [COEF_W-1:0] sum;
        logic             ovf;
        rows = max_row_cfg + 1;
        if (rows > ROWS)
            rows = ROWS;
        for (int unsigned n = 0; n < rows; n++)
        begin
            tri_value[slot_of(n, 0)] = COEF_W'(1);
            tri_ovf[slot_of(n, 0)] = 1'b0;
            tri_value[slot_of(n, n)] = COEF_W'(1);
            tri_ovf[slot_of(n, n)] = 1'b0;
            for (int unsigned k = 1; k < n; k++)
            begin
                pa = slot_of(n - 1, k - 1);
                pb = slot_of(n - 1, k);
                sum = tri_value[pa] + tri_value[pb];
                ovf = tri_ovf[pa] || tri_ovf[pb] || (sum > SIGNED_MAX);
                tri_ovf[slot_of(n, k)] = ovf;
                tri_value[slot_of(n, k)] = ovf ? '1 : sum;
            end
        end
        rows_in_table = ROWS_W'(rows);
    endfunction

    function automatic coef_reply_t lookup_coefficient(logic op, logic [IDX_W-1:0] n,
                                                       logic [IDX_W-1:0] k);
        coef_reply_t r;
        int unsigned s;
        r = '0;
        if (op == OP_BUILD)
        begin
            fill_triangle();
            n_builds++;
        end
        else if (n >= rows_in_table || k > n)
        begin
            r.oor = 1'b1;
            n_range++;
        end
        else
        begin
            s = slot_of(n, k);
            if (tri_ovf[s])
            begin
                r.ovf = 1'b1;
                r.coef = '1;
            end
            else
                r.coef = tri_value[s];
        end
        r.rows = rows_in_table;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_coefs.delete();
            rows_in_table = '0;
            max_row_cfg = MAX_ROW_RESET;
        end
        else
        begin
            // register write, or readback against the shadow copy
            if (psel && penable && pready === 1'b1 && paddr == MAX_ROW_ADDR)
            begin
                if (pwrite)
                    max_row_cfg = pwdata[MAX_ROW_W-1:0];
                else if (prdata !== APB_DATA_W'(max_row_cfg))
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("checker: max_row readback exp %0d got %0h",
                                 max_row_cfg, prdata);
                end
            end

            // accepted item
            if (in_valid && in_stall === 1'b0)
                expected_coefs.push_back(lookup_coefficient(opcode, row_index, column_index));

            // accepted result against the oldest expectation
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (expected_coefs.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("checker: unexpected result coef=%0d ovf=%0b oor=%0b rows=%0d",
                                 coefficient, overflowed, out_of_range, rows_built);
                end
                else
                begin
                    want = expected_coefs.pop_front();
                    n_checked++;
                    if (coefficient !== want.coef || overflowed !== want.ovf ||
                        out_of_range !== want.oor || rows_built !== want.rows)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"checker: result %0d exp coef=%0d ovf=%0b oor=%0b ",
                                      "rows=%0d, got coef=%0d ovf=%0b oor=%0b rows=%0d"},
                                     n_checked, want.coef, want.ovf, want.oor, want.rows,
                                     coefficient, overflowed, out_of_range, rows_built);
                    end
                end
            end
        end
        // published through nonblocking assignments so the stimulus side reads them race-free
        pending <= expected_coefs.size();
        mismatches <= err_count;
        results_checked <= n_checked;
        builds_seen <= n_builds;
        range_errors <= n_range;
    end

endmodule

/* verif/tb.sv */
// Top of the binomial coefficient table testbench: clock, reset, items, register
// writes and the verdict. Depends on bct_pkg, the block and coefficient_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bct_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PHASES = 10;
    localparam int unsigned PHASE_ITEMS = 175;
    localparam logic [APB_ADDR_W-1:0] MAX_ROW_ADDR = APB_ADDR_W'(4 * REG_MAX_ROW);

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      opcode = OP_BUILD;
    logic [IDX_W-1:0]          row_index = '0;
    logic [IDX_W-1:0]          column_index = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COEF_W-1:0]  coefficient;
    logic                      overflowed;
    logic                      out_of_range;
    logic [ROWS_W-1:0]         rows_built;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0]     pwdata = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    // no idling on either side while set
    logic                      steady = 1'b0;
    // rows of the last build issued, used to aim queries inside the table
    int unsigned               table_rows = 0;
    logic [MAX_ROW_W-1:0]      row_setting = MAX_ROW_RESET;
    logic [MAX_ROW_W-1:0]      plan [PHASES] = '{6'd63, 6'd0, 6'd1, 6'd17, 6'd63,
                                                 6'd5, 6'd2, 6'd40, 6'd62, 6'd9};
    int unsigned               cycle_count = 0;

    int unsigned               mismatches;
    int unsigned               pending;
    int unsigned               results_checked;
    int unsigned               builds_seen;
    int unsigned               range_errors;

    binomial_coefficient_table #(.MAX_ROWS(MAX_ROWS_DEF)) uut (.*);

    coefficient_checker #(.ROWS(MAX_ROWS_DEF)) u_checker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side backpressure
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 23);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // one item, with random idle cycles ahead of it, held until accepted
    task automatic send_item(input logic op, input logic [IDX_W-1:0] n,
                             input logic [IDX_W-1:0] k);
        while (!steady && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        row_index <= n;
        column_index <= k;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        if (op == OP_BUILD)
            table_rows = (row_setting + 1 > ROWS_LIMIT) ? ROWS_LIMIT : row_setting + 1;
    endtask

    // drain: no input, every expected result in, then a short settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= MAX_ROW_ADDR;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // write max_row with junk in the unused bits, then read it back
    task automatic set_max_row(input logic [MAX_ROW_W-1:0] value);
        wait_idle();
        row_setting = value;
        apb_access(1'b1, (APB_DATA_W'($urandom) << MAX_ROW_W) | APB_DATA_W'(value));
        apb_access(1'b0, '0);
    endtask

    // mostly queries inside the table, a few builds, some out-of-range noise
    task automatic random_item();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        pick = $urandom_range(99);
        if (pick < 3)
            send_item(OP_BUILD, IDX_W'($urandom), IDX_W'($urandom));
        else if (pick < 88 && table_rows != 0)
        begin
            n = $urandom_range(table_rows - 1);
            case ($urandom_range(4))
                0: k = 0;
                1: k = n;
                default: k = $urandom_range(n);
            endcase
            send_item(OP_QUERY, IDX_W'(n), IDX_W'(k));
        end
        else
        begin
            case ($urandom_range(2))
                0:
                begin
                    n = $urandom_range(255, table_rows);
                    k = $urandom_range(255);
                end
                1:
                begin
                    n = $urandom_range(254);
                    k = $urandom_range(255, n + 1);
                end
                default:
                begin
                    n = $urandom_range(255);
                    k = $urandom_range(255);
                end
            endcase
            send_item(OP_QUERY, IDX_W'(n), IDX_W'(k));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queries before any build are all out of range
        send_item(OP_QUERY, 0, 0);
        send_item(OP_QUERY, 255, 255);
        // full triangle at the reset setting, then its corners, edges, middle entries and out-of-range points
        send_item(OP_BUILD, 0, 0);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_QUERY, 63, 0);
        send_item(OP_QUERY, 63, 63);
        send_item(OP_QUERY, 63, 31);
        send_item(OP_QUERY, 63, 32);
        send_item(OP_QUERY, 62, 31);
        send_item(OP_QUERY, 1, 1);
        send_item(OP_QUERY, 2, 1);
        send_item(OP_QUERY, 63, 64);
        send_item(OP_QUERY, 64, 0);
        send_item(OP_QUERY, 255, 255);
        send_item(OP_QUERY, 0, 255);
        send_item(OP_QUERY, 128, 127);
        // shrink to a single row
        set_max_row(6'd0);
        send_item(OP_BUILD, 8'hFF, 8'hFF);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_QUERY, 1, 0);
        send_item(OP_QUERY, 0, 1);

        // random phases, each at its own max_row setting
        for (int unsigned phase = 0; phase < PHASES; phase++)
        begin
            set_max_row((phase % 3 == 2) ? MAX_ROW_W'($urandom_range(63)) : plan[phase]);
            steady <= (phase == 4);
            for (int unsigned i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == 4)
                    send_item(OP_BUILD, IDX_W'($urandom), IDX_W'($urandom));
                else
                    random_item();
            end
        end
        steady <= 1'b0;
        wait_idle();

        $display("tb: %0d results checked: %0d builds, %0d out-of-range queries, %0d settings",
                 results_checked, builds_seen, range_errors, PHASES + 1);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/bct_pkg.sv
rtl/bct_apb.sv
rtl/bct_store.sv
rtl/bct_sum.sv
rtl/bct_ctrl.sv
rtl/binomial_coefficient_table.sv
verif/coefficient_checker.sv
verif/tb.sv
